// ===== sv/bpfa_pkg.sv =====
// Shared types and constants of the bitmap page frame allocator.
package bpfa_pkg;

    // Field widths of the request and response channels
    localparam int ACTION_W       = 2;
    localparam int PAGE_FRAME_W   = 12;
    localparam int PRIV_W         = 2;
    localparam int ADDR_W         = 32;
    localparam int STATUS_W       = 3;
    localparam int WORD_COUNT_W   = 8;

    // Bitmap geometry
    localparam int WORD_BITS      = 32;
    localparam int BIT_IDX_W      = 5;
    localparam int PAGE_SHIFT     = 12;
    localparam int FRAME_IDX_W    = ADDR_W - PAGE_SHIFT;

    // Defaults
    localparam int                      NUM_FRAMES_DEFAULT = 4096;
    localparam logic [WORD_COUNT_W-1:0] WORD_COUNT_RESET   = 8'd128;

    // Privilege levels
    localparam logic [PRIV_W-1:0] PRIV_USER   = 2'd0;
    localparam logic [PRIV_W-1:0] PRIV_KERNEL = 2'd1;

    // Request actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_TEST  = 2'd2,
        ACT_MARK  = 2'd3
    } t_action;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_DONE     = 3'd0,
        STS_NOTHING  = 3'd1,
        STS_BAD_PRIV = 3'd2,
        STS_NO_FRAME = 3'd3,
        STS_RANGE    = 3'd4
    } t_status;

    // Operations handed from the front end to the back end
    typedef enum logic [2:0] {
        OP_REPORT,
        OP_ALLOC,
        OP_FREE,
        OP_TEST,
        OP_MARK
    } t_op;

    // Classified command
    typedef struct packed {
        t_op                    op;
        t_status                status;
        logic [FRAME_IDX_W-1:0] frame;
        logic                   writable;
        logic                   user;
    } t_cmd;

    // Response payload
    typedef struct packed {
        t_status                 status;
        logic [PAGE_FRAME_W-1:0] frame_out;
        logic                    present_bit;
        logic                    rw_bit;
        logic                    user_bit;
        logic                    is_used;
    } t_res;

    // Back end states
    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_RMW,
        BS_RESP
    } t_bstate;

endpackage

// ===== sv/bpfa_if.sv =====
// Channel interfaces of the bitmap page frame allocator.

// Request channel
interface bpfa_in_if;
    logic                                valid;
    logic                                ready;
    logic [bpfa_pkg::ACTION_W-1:0]       action;
    logic [bpfa_pkg::PAGE_FRAME_W-1:0]   page_frame;
    logic [bpfa_pkg::PRIV_W-1:0]         privilege;
    logic                                writable;
    logic [bpfa_pkg::ADDR_W-1:0]         address;

    modport source (output valid, action, page_frame, privilege, writable, address,
                    input ready);
    modport sink   (input valid, action, page_frame, privilege, writable, address,
                    output ready);
endinterface

// Response channel
interface bpfa_out_if;
    logic                                valid;
    logic                                ready;
    logic [bpfa_pkg::STATUS_W-1:0]       status;
    logic [bpfa_pkg::PAGE_FRAME_W-1:0]   frame_out;
    logic                                present_bit;
    logic                                rw_bit;
    logic                                user_bit;
    logic                                is_used;

    modport source (output valid, status, frame_out, present_bit, rw_bit, user_bit, is_used,
                    input ready);
    modport sink   (input valid, status, frame_out, present_bit, rw_bit, user_bit, is_used,
                    output ready);
endinterface

// Configuration write channel
interface bpfa_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [bpfa_pkg::WORD_COUNT_W-1:0]     data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== sv/bpfa_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module bpfa_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 128,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/bpfa_front.sv =====
// Front end: accepts requests and classifies them into commands.
module bpfa_front #(
    parameter int NUM_FRAMES = bpfa_pkg::NUM_FRAMES_DEFAULT
) (
    bpfa_in_if.sink              i_in,
    input  logic                 i_queue_full,
    input  logic                 i_back_ready,
    output logic                 o_push,
    output bpfa_pkg::t_cmd       o_cmd
);
    localparam logic [31:0] NF32 = 32'(NUM_FRAMES);

    logic [31:0] pf_ext;
    logic [31:0] addr_frame_ext;
    logic        pf_range_bad;
    logic        addr_range_bad;

    // Take a request only with queue room and the bitmap cleared
    assign i_in.ready = !i_queue_full && i_back_ready;
    assign o_push     = i_in.valid && i_in.ready;

    assign pf_ext         = 32'(i_in.page_frame);
    assign addr_frame_ext = 32'(i_in.address[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_SHIFT]);
    assign pf_range_bad   = pf_ext >= NF32;
    assign addr_range_bad = addr_frame_ext >= NF32;

    // Classify the request
    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = bpfa_pkg::OP_REPORT;
        o_cmd.status   = bpfa_pkg::STS_DONE;
        o_cmd.writable = i_in.writable;
        o_cmd.user     = (i_in.privilege == bpfa_pkg::PRIV_USER);
        unique case (bpfa_pkg::t_action'(i_in.action))
            bpfa_pkg::ACT_ALLOC: begin
                priority if (i_in.privilege > bpfa_pkg::PRIV_KERNEL) begin
                    o_cmd.status = bpfa_pkg::STS_BAD_PRIV;
                end else if (i_in.page_frame != '0) begin
                    o_cmd.status = bpfa_pkg::STS_NOTHING;
                end else begin
                    o_cmd.op = bpfa_pkg::OP_ALLOC;
                end
            end
            bpfa_pkg::ACT_FREE: begin
                o_cmd.frame = pf_ext[bpfa_pkg::FRAME_IDX_W-1:0];
                priority if (i_in.page_frame == '0) begin
                    o_cmd.status = bpfa_pkg::STS_NOTHING;
                end else if (pf_range_bad) begin
                    o_cmd.status = bpfa_pkg::STS_RANGE;
                end else begin
                    o_cmd.op = bpfa_pkg::OP_FREE;
                end
            end
            bpfa_pkg::ACT_TEST: begin
                o_cmd.frame = addr_frame_ext[bpfa_pkg::FRAME_IDX_W-1:0];
                if (addr_range_bad) begin
                    o_cmd.status = bpfa_pkg::STS_RANGE;
                end else begin
                    o_cmd.op = bpfa_pkg::OP_TEST;
                end
            end
            bpfa_pkg::ACT_MARK: begin
                o_cmd.frame = addr_frame_ext[bpfa_pkg::FRAME_IDX_W-1:0];
                if (addr_range_bad) begin
                    o_cmd.status = bpfa_pkg::STS_RANGE;
                end else begin
                    o_cmd.op = bpfa_pkg::OP_MARK;
                end
            end
            default: begin
                o_cmd.status = bpfa_pkg::STS_NOTHING;
            end
        endcase
    end

endmodule

// ===== sv/bpfa_cmd_fifo.sv =====
// Two-entry command queue between the front end and the back end.
module bpfa_cmd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bpfa_pkg::t_cmd       i_cmd,
    output logic                 o_full,
    output logic                 o_valid,
    output bpfa_pkg::t_cmd       o_cmd,
    input  logic                 i_pop
);
    bpfa_pkg::t_cmd r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_cmd   = r_mem[r_rptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_valid)
        else $error("command queue popped while empty");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_full |-> !i_push || i_pop)
        else $error("command queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     (i_push && !i_pop) |=> r_count == $past(r_count) + 2'd1)
        else $error("command queue count lost a push");

endmodule

// ===== sv/bpfa_back.sv =====
// Back end: bitmap storage, first-fit search and read-modify-write sequencer.
module bpfa_back #(
    parameter int NUM_FRAMES = bpfa_pkg::NUM_FRAMES_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bpfa_cfg_if.sink             i_cfg,
    input  logic                 i_cmd_valid,
    input  bpfa_pkg::t_cmd       i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_ready,
    bpfa_out_if.source           o_out
);
    localparam int WORDS     = (NUM_FRAMES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
    localparam int WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LAST_BITS = NUM_FRAMES - (WORDS - 1) * bpfa_pkg::WORD_BITS;
    localparam logic [bpfa_pkg::WORD_BITS-1:0] PAD_MASK =
        (LAST_BITS == bpfa_pkg::WORD_BITS) ? '0 :
        ~((32'h1 << LAST_BITS) - 32'h1);
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);

    bpfa_pkg::t_bstate r_state, n_state;
    logic [WORD_AW-1:0]                     r_clr_addr;
    logic [WORDS-1:0]                       r_full;
    logic [bpfa_pkg::WORD_COUNT_W-1:0]      r_word_count;
    bpfa_pkg::t_cmd                         r_cmd;
    logic [WORD_AW-1:0]                     r_waddr;
    bpfa_pkg::t_res                         r_res;
    logic                                   r_out_valid;
    bpfa_pkg::t_res                         r_out;

    logic [WORDS-1:0]                       avail;
    logic [WORDS-1:0]                       avail_low;
    logic                                   any_avail;
    logic [WORD_AW-1:0]                     search_idx;
    logic [31:0]                            cmd_word_ext;
    logic [WORD_AW-1:0]                     cmd_word;

    logic                                   ram_we;
    logic [WORD_AW-1:0]                     ram_waddr;
    logic [bpfa_pkg::WORD_BITS-1:0]         ram_wdata;
    logic [WORD_AW-1:0]                     ram_raddr;
    logic [bpfa_pkg::WORD_BITS-1:0]         ram_rdata;

    logic [bpfa_pkg::WORD_BITS-1:0]         pad_sel;
    logic [bpfa_pkg::WORD_BITS-1:0]         padded;
    logic [bpfa_pkg::WORD_BITS-1:0]         zero_low;
    logic [bpfa_pkg::BIT_IDX_W-1:0]         zero_idx;
    logic [bpfa_pkg::BIT_IDX_W-1:0]         bit_idx;
    logic [bpfa_pkg::WORD_BITS-1:0]         new_word;
    logic [31:0]                            alloc_frame;
    bpfa_pkg::t_res                         rmw_res;

    logic                                   slot_free;
    logic                                   start_rmw;
    logic                                   out_load;
    bpfa_pkg::t_res                         out_data;

    bpfa_ram #(
        .WIDTH (bpfa_pkg::WORD_BITS),
        .DEPTH (WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_cfg.ready = 1'b1;
    assign o_ready     = r_state != bpfa_pkg::BS_CLEAR;
    assign slot_free   = !r_out_valid || o_out.ready;

    // First word with a free frame among the searched words
    always_comb begin
        for (int i = 0; i < WORDS; i++) begin
            avail[i] = !r_full[i] && (32'(i) < 32'(r_word_count));
        end
    end
    assign avail_low = avail & (~avail + WORDS'(1));
    assign any_avail = |avail;
    always_comb begin
        search_idx = '0;
        for (int i = 0; i < WORDS; i++) begin
            if (avail_low[i]) begin
                search_idx = search_idx | WORD_AW'(i);
            end
        end
    end

    assign cmd_word_ext = 32'(i_cmd.frame) >> bpfa_pkg::BIT_IDX_W;
    assign cmd_word     = cmd_word_ext[WORD_AW-1:0];

    // Lowest clear bit of the word just read, padding counted as used
    assign pad_sel  = (r_waddr == LAST_WORD) ? PAD_MASK : '0;
    assign padded   = ram_rdata | pad_sel;
    assign zero_low = ~padded & (padded + 32'h1);
    always_comb begin
        zero_idx = '0;
        for (int j = 0; j < bpfa_pkg::WORD_BITS; j++) begin
            if (zero_low[j]) begin
                zero_idx = zero_idx | bpfa_pkg::BIT_IDX_W'(j);
            end
        end
    end

    // Modified word and result of the read-modify-write step
    assign bit_idx = (r_cmd.op == bpfa_pkg::OP_ALLOC) ? zero_idx
                                                      : r_cmd.frame[bpfa_pkg::BIT_IDX_W-1:0];
    assign alloc_frame = (32'(r_waddr) << bpfa_pkg::BIT_IDX_W) | 32'(zero_idx);
    always_comb begin
        new_word = ram_rdata;
        unique case (r_cmd.op)
            bpfa_pkg::OP_ALLOC: new_word = ram_rdata | zero_low;
            bpfa_pkg::OP_FREE:  new_word = ram_rdata & ~(32'h1 << bit_idx);
            bpfa_pkg::OP_MARK:  new_word = ram_rdata | (32'h1 << bit_idx);
            default:            new_word = ram_rdata;
        endcase
    end
    always_comb begin
        rmw_res        = '0;
        rmw_res.status = bpfa_pkg::STS_DONE;
        if (r_cmd.op == bpfa_pkg::OP_ALLOC) begin
            rmw_res.frame_out   = alloc_frame[bpfa_pkg::PAGE_FRAME_W-1:0];
            rmw_res.present_bit = 1'b1;
            rmw_res.rw_bit      = r_cmd.writable;
            rmw_res.user_bit    = r_cmd.user;
        end
        if (r_cmd.op == bpfa_pkg::OP_TEST) begin
            rmw_res.is_used = ram_rdata[bit_idx];
        end
    end

    assign start_rmw = i_cmd_valid &&
                       ((i_cmd.op == bpfa_pkg::OP_ALLOC) ? any_avail
                                                        : (i_cmd.op != bpfa_pkg::OP_REPORT));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpfa_pkg::BS_CLEAR: if (r_clr_addr == LAST_WORD) n_state = bpfa_pkg::BS_IDLE;
            bpfa_pkg::BS_IDLE:  if (start_rmw) n_state = bpfa_pkg::BS_RMW;
            bpfa_pkg::BS_RMW:   n_state = bpfa_pkg::BS_RESP;
            bpfa_pkg::BS_RESP:  if (slot_free) n_state = bpfa_pkg::BS_IDLE;
            default:            n_state = bpfa_pkg::BS_CLEAR;
        endcase
    end

    // State outputs: queue pop, memory port, output register load
    always_comb begin
        o_cmd_pop       = 1'b0;
        out_load        = 1'b0;
        out_data        = r_res;
        ram_we          = 1'b0;
        ram_waddr       = r_waddr;
        ram_wdata       = new_word;
        ram_raddr       = (i_cmd.op == bpfa_pkg::OP_ALLOC) ? search_idx : cmd_word;
        unique case (r_state)
            bpfa_pkg::BS_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            bpfa_pkg::BS_IDLE: begin
                out_data        = '0;
                out_data.status = (i_cmd.op == bpfa_pkg::OP_ALLOC) ? bpfa_pkg::STS_NO_FRAME
                                                                   : i_cmd.status;
                out_load        = i_cmd_valid && !start_rmw && slot_free;
                o_cmd_pop       = start_rmw || out_load;
            end
            bpfa_pkg::BS_RMW: begin
                ram_we = r_cmd.op != bpfa_pkg::OP_TEST;
            end
            bpfa_pkg::BS_RESP: begin
                out_load = slot_free;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bpfa_pkg::BS_CLEAR;
            r_clr_addr   <= '0;
            r_full       <= '0;
            r_word_count <= bpfa_pkg::WORD_COUNT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bpfa_pkg::BS_CLEAR) begin
                r_clr_addr <= r_clr_addr + WORD_AW'(1);
            end
            if (r_state == bpfa_pkg::BS_RMW && ram_we) begin
                r_full[r_waddr] <= &(new_word | pad_sel);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_word_count <= i_cfg.data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == bpfa_pkg::BS_IDLE && start_rmw) begin
            r_cmd   <= i_cmd;
            r_waddr <= ram_raddr;
        end
        if (r_state == bpfa_pkg::BS_RMW) begin
            r_res <= rmw_res;
        end
        if (out_load) begin
            r_out <= out_data;
        end
    end

    // Drive the response channel
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out.status;
    assign o_out.frame_out   = r_out.frame_out;
    assign o_out.present_bit = r_out.present_bit;
    assign o_out.rw_bit      = r_out.rw_bit;
    assign o_out.user_bit    = r_out.user_bit;
    assign o_out.is_used     = r_out.is_used;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     out_load |-> (!r_out_valid || o_out.ready))
        else $error("response register overwritten before transfer");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     (r_state == bpfa_pkg::BS_RMW && r_cmd.op == bpfa_pkg::OP_ALLOC)
                     |-> !(&padded))
        else $error("full-word summary disagrees with bitmap word");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     o_cmd_pop |-> r_state == bpfa_pkg::BS_IDLE && i_cmd_valid)
        else $error("command taken outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     (r_out_valid && r_out.present_bit) |-> r_out.status == bpfa_pkg::STS_DONE)
        else $error("present bit set on a failed allocation");

endmodule

// ===== sv/bitmap_page_frame_allocator.sv =====
// Top level of the bitmap first-fit page frame allocator.
//
//  channel  | dir | handshake     | payload
//  i_in     | in  | valid / ready | action, page_frame, privilege, writable, address
//  o_out    | out | valid / ready | status, frame_out, present_bit, rw_bit, user_bit, is_used
//  i_cfg    | in  | valid / ready | data = word_count (always ready)
//
//  Allocate, free, test and mark go through search and read, then write back (none
//  for test), then response; rejected or early answered requests are answered
//  straight from idle. After reset the bitmap RAM is cleared one word a cycle,
//  (NUM_FRAMES+31)/32 words, with i_in.ready low. A two-entry command queue lets
//  requests enter while the response register waits on o_out.ready.
module bitmap_page_frame_allocator #(
    parameter int NUM_FRAMES = bpfa_pkg::NUM_FRAMES_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bpfa_in_if.sink      i_in,
    bpfa_cfg_if.sink     i_cfg,
    bpfa_out_if.source   o_out
);
    logic           push;
    bpfa_pkg::t_cmd push_cmd;
    logic           queue_full;
    logic           queue_valid;
    bpfa_pkg::t_cmd queue_cmd;
    logic           queue_pop;
    logic           back_ready;

    // Classify requests
    bpfa_front #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_front (
        .i_in         (i_in),
        .i_queue_full (queue_full),
        .i_back_ready (back_ready),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // Hold classified commands
    bpfa_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd),
        .i_pop   (queue_pop)
    );

    // Execute commands against the bitmap
    bpfa_back #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_ready     (back_ready),
        .o_out       (o_out)
    );

endmodule
